### hdl/rtwc_pkg.sv
// Shared widths, constants and sequencer states for the route time window checker.
package rtwc_pkg;

	localparam int COORD_BITS   = 10;
	localparam int TIME_BITS    = 16;
	localparam int DEMAND_BITS  = 10;
	localparam int CAP_BITS     = 16;

	localparam int ELAPSED_BITS = TIME_BITS + 1;
	localparam int LOAD_BITS    = CAP_BITS + 1;
	localparam int SUM_BITS     = ELAPSED_BITS + 2;

	// shared squarer operand and product
	localparam int OP_BITS      = (COORD_BITS > TIME_BITS) ? COORD_BITS : TIME_BITS;
	localparam int PROD_BITS    = 2 * OP_BITS;
	localparam int D2_BITS      = 2 * COORD_BITS + 1;
	localparam int WIDE_BITS    = PROD_BITS + 1;

	// square root: one result bit per step
	localparam int ROOT_BITS    = COORD_BITS + 1;
	localparam int RAD_BITS     = 2 * ROOT_BITS;
	localparam int REM_BITS     = ROOT_BITS + 2;
	localparam int CNT_BITS     = (ROOT_BITS > 1) ? $clog2(ROOT_BITS) : 1;

	localparam logic [CAP_BITS-1:0]     CAP_RESET   = CAP_BITS'(200);
	localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_DX,
		ST_SQ_DY,
		ST_SQ_SLACK,
		ST_CHECK,
		ST_ROOT,
		ST_ARRIVE,
		ST_UPDATE,
		ST_FINISH
	} rtwc_state_t;

endpackage

### hdl/rtwc_channels.sv
// Handshake channels of the route time window checker: stops in, results out, capacity writes.
interface rtwc_stop_if import rtwc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [COORD_BITS-1:0]  x_coord;
	logic [COORD_BITS-1:0]  y_coord;
	logic [DEMAND_BITS-1:0] demand;
	logic [TIME_BITS-1:0]   open_time;
	logic [TIME_BITS-1:0]   due_time;
	logic [TIME_BITS-1:0]   service_time;
	logic                   last_stop;

	modport source (output valid, x_coord, y_coord, demand, open_time, due_time,
		service_time, last_stop, input ready);
	modport sink (input valid, x_coord, y_coord, demand, open_time, due_time,
		service_time, last_stop, output ready);
endinterface

interface rtwc_result_if import rtwc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    feasible;
	logic [ELAPSED_BITS-1:0] route_time;

	modport source (output valid, feasible, route_time, input ready);
	modport sink (input valid, feasible, route_time, output ready);
endinterface

interface rtwc_cfg_if import rtwc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CAP_BITS-1:0] vehicle_capacity;

	modport source (output valid, vehicle_capacity, input ready);
	modport sink (input valid, vehicle_capacity, output ready);
endinterface

### hdl/route_time_window_check.sv
// Route time window checker: top level with sequencer, shared squarer and bit-serial root.
//
//  channel  dir  word                                           note
//  -------  ---  ---------------------------------------------  ------------------------
//  stop     in   x/y, demand, ready/due/service time, last_stop  one stop of a route
//  result   out  feasible, route_time                            one word per route
//  cfg      in   vehicle_capacity                                always ready
//
// A full stop runs through accept, three squarings on the one multiplier
// (dx, dy, slack), check, 11 square root steps of one result bit each, arrive,
// update, finish. The square root steps are the longest part.
// The first stop of a route, and any stop after a failure, goes from accept to finish.
// Reset: capacity 200, next stop opens a new route, no result pending.
// The result register lets the next stop in while a result waits; only a
// last stop stalls in finish, while the previous result is still untaken.
module route_time_window_check import rtwc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	rtwc_stop_if.sink      stop,
	rtwc_result_if.source  result,
	rtwc_cfg_if.sink       cfg
);

	rtwc_state_t state_q, state_d;

	// route state
	logic                    at_start_q;
	logic                    failed_q;
	logic [ELAPSED_BITS-1:0] elapsed_q;
	logic [LOAD_BITS-1:0]    load_q;
	logic [CAP_BITS-1:0]     cap_q;
	logic [COORD_BITS-1:0]   prev_x_q;
	logic [COORD_BITS-1:0]   prev_y_q;

	// captured stop
	logic [DEMAND_BITS-1:0]  demand_q;
	logic [TIME_BITS-1:0]    ready_q;
	logic [TIME_BITS-1:0]    serv_q;
	logic                    last_q;
	logic [COORD_BITS-1:0]   dx_q;
	logic [COORD_BITS-1:0]   dy_q;
	logic [TIME_BITS-1:0]    slack_q;
	logic                    late_q;

	// squarer and root datapath
	logic [D2_BITS-1:0]      d2_q;
	logic [PROD_BITS-1:0]    slack2_q;
	logic [RAD_BITS-1:0]     rad_q;
	logic [REM_BITS-1:0]     rem_q;
	logic [ROOT_BITS-1:0]    root_q;
	logic [CNT_BITS-1:0]     cnt_q;
	logic [SUM_BITS-1:0]     t_q;

	// result register
	logic                    out_valid_q;
	logic                    out_feasible_q;
	logic [ELAPSED_BITS-1:0] out_time_q;

	logic                    accept;
	logic                    fin_load;
	logic                    too_far;
	logic                    root_done;
	logic [OP_BITS-1:0]      mul_op;
	logic [PROD_BITS-1:0]    sq;
	logic [REM_BITS-1:0]     rem_shift;
	logic [REM_BITS-1:0]     trial;
	logic                    take;
	logic [SUM_BITS-1:0]     t_arr;
	logic [SUM_BITS-1:0]     t_sum;
	logic [LOAD_BITS-1:0]    load_sum;

	assign accept    = stop.valid && stop.ready;
	assign fin_load  = last_q && (!out_valid_q || result.ready);
	assign too_far   = late_q || (WIDE_BITS'(d2_q) > WIDE_BITS'(slack2_q));
	assign root_done = (cnt_q == CNT_BITS'(ROOT_BITS - 1));

	// one shared squarer
	always_comb begin
		unique case (state_q)
			ST_SQ_DX: mul_op = OP_BITS'(dx_q);
			ST_SQ_DY: mul_op = OP_BITS'(dy_q);
			default:  mul_op = OP_BITS'(slack_q);
		endcase
	end
	assign sq = PROD_BITS'(mul_op) * PROD_BITS'(mul_op);

	// root step: bring down two radicand bits, try (root << 2) | 1
	assign rem_shift = {rem_q[REM_BITS-3:0], rad_q[RAD_BITS-1 -: 2]};
	assign trial     = {root_q, 2'b01};
	assign take      = (rem_shift >= trial);

	// arrival, then wait for ready time
	assign t_arr    = SUM_BITS'(elapsed_q) + SUM_BITS'(root_q);
	assign t_sum    = t_q + SUM_BITS'(serv_q);
	assign load_sum = load_q + LOAD_BITS'(demand_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (at_start_q || failed_q) ? ST_FINISH : ST_SQ_DX;
				end
			end
			ST_SQ_DX:    state_d = ST_SQ_DY;
			ST_SQ_DY:    state_d = ST_SQ_SLACK;
			ST_SQ_SLACK: state_d = ST_CHECK;
			ST_CHECK:    state_d = too_far ? ST_FINISH : ST_ROOT;
			ST_ROOT: begin
				if (root_done) begin
					state_d = ST_ARRIVE;
				end
			end
			ST_ARRIVE:   state_d = ST_UPDATE;
			ST_UPDATE:   state_d = ST_FINISH;
			ST_FINISH: begin
				if (!last_q || fin_load) begin
					state_d = ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// port outputs
	always_comb begin
		stop.ready        = (state_q == ST_IDLE);
		cfg.ready         = 1'b1;
		result.valid      = out_valid_q;
		result.feasible   = out_feasible_q;
		result.route_time = out_time_q;
	end

	// control and route state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			at_start_q  <= 1'b1;
			failed_q    <= 1'b0;
			elapsed_q   <= '0;
			load_q      <= '0;
			cap_q       <= CAP_RESET;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				cap_q <= cfg.vehicle_capacity;
			end
			// a new word out of finish wins over the taking of the old one
			if (state_q == ST_FINISH && fin_load) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && at_start_q) begin
						at_start_q <= 1'b0;
					end
				end
				ST_CHECK: begin
					cnt_q <= '0;
					if (too_far) begin
						failed_q <= 1'b1;
					end
				end
				ST_ROOT: begin
					cnt_q <= cnt_q + 1'b1;
				end
				ST_UPDATE: begin
					elapsed_q <= (t_sum > SUM_BITS'(ELAPSED_MAX)) ? ELAPSED_MAX
						: ELAPSED_BITS'(t_sum);
					if (load_sum > LOAD_BITS'(cap_q)) begin
						failed_q <= 1'b1;
					end else begin
						load_q <= load_sum;
					end
				end
				ST_FINISH: begin
					if (fin_load) begin
						at_start_q  <= 1'b1;
						failed_q    <= 1'b0;
						elapsed_q   <= '0;
						load_q      <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					prev_x_q <= stop.x_coord;
					prev_y_q <= stop.y_coord;
					demand_q <= stop.demand;
					ready_q  <= stop.open_time;
					serv_q   <= stop.service_time;
					last_q   <= stop.last_stop;
					dx_q     <= (stop.x_coord >= prev_x_q) ? stop.x_coord - prev_x_q
						: prev_x_q - stop.x_coord;
					dy_q     <= (stop.y_coord >= prev_y_q) ? stop.y_coord - prev_y_q
						: prev_y_q - stop.y_coord;
					late_q   <= (ELAPSED_BITS'(stop.due_time) < elapsed_q);
					slack_q  <= stop.due_time - elapsed_q[TIME_BITS-1:0];
				end
			end
			ST_SQ_DX:    d2_q     <= D2_BITS'(sq);
			ST_SQ_DY:    d2_q     <= d2_q + D2_BITS'(sq);
			ST_SQ_SLACK: slack2_q <= sq;
			ST_CHECK: begin
				rad_q  <= RAD_BITS'(d2_q);
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_ROOT: begin
				rad_q  <= {rad_q[RAD_BITS-3:0], 2'b00};
				rem_q  <= take ? rem_shift - trial : rem_shift;
				root_q <= {root_q[ROOT_BITS-2:0], take};
			end
			ST_ARRIVE: begin
				t_q <= (t_arr < SUM_BITS'(ready_q)) ? SUM_BITS'(ready_q) : t_arr;
			end
			ST_FINISH: begin
				if (fin_load) begin
					out_feasible_q <= !failed_q;
					out_time_q     <= failed_q ? '0 : elapsed_q;
				end
			end
			default: ;
		endcase
	end

	// a result word only appears out of finish
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q == ST_FINISH))
		else $error("result word raised outside finish");

	// a failed route reports zero time
	a_fail_zero_time: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.feasible |-> result.route_time == '0)
		else $error("infeasible route with non-zero time");

	// one stop at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		stop.valid && stop.ready |=> !stop.ready)
		else $error("stop taken while previous stop in flight");

	// root step counter stays within the result width
	a_root_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROOT |-> cnt_q <= CNT_BITS'(ROOT_BITS - 1))
		else $error("square root step count overrun");

endmodule
